@@ sv/byte_alu_with_flag_selects_assert.svh @@
// Assertion macros for the byte ALU with flag selects.
// Used by the top level; no other dependencies.
`ifndef BYTE_ALU_WITH_FLAG_SELECTS_ASSERT_SVH
`define BYTE_ALU_WITH_FLAG_SELECTS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BAFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bafs_pkg.sv @@
// Shared types and select codes for the byte ALU with flag selects.
// No dependencies; used by the datapath and the top level.
package bafs_pkg;

  // Shift stage selects.
  typedef enum logic [1:0] {
    SHIFT_PASS = 2'd0,
    SHIFT_ROR  = 2'd1,
    SHIFT_ASR  = 2'd2,
    SHIFT_ZERO = 2'd3
  } shift_sel_e;

  // Logic stage selects; the remaining codes give zero.
  typedef enum logic [3:0] {
    LOGIC_ZERO     = 4'd0,
    LOGIC_ONES     = 4'd1,
    LOGIC_LEFT     = 4'd2,
    LOGIC_RIGHT    = 4'd3,
    LOGIC_NOT_LEFT = 4'd4,
    LOGIC_NOT_RIGHT = 4'd5,
    LOGIC_OR       = 4'd6,
    LOGIC_AND      = 4'd7,
    LOGIC_XOR      = 4'd8
  } logic_sel_e;

  // Adder carry-in selects; the spare code gives zero.
  typedef enum logic [1:0] {
    CIN_ZERO  = 2'd0,
    CIN_CARRY = 2'd1,
    CIN_ONE   = 2'd2
  } cin_sel_e;

  // Carry flag selects; the spare codes keep the flag.
  typedef enum logic [2:0] {
    CARRY_ONE   = 3'd0,
    CARRY_SHIFT = 3'd1,
    CARRY_SUM   = 3'd2,
    CARRY_ZERO  = 3'd3,
    CARRY_KEEP  = 3'd4
  } carry_sel_e;

  // Zero, overflow and negative flag selects.
  typedef enum logic [1:0] {
    FLAG_ONE  = 2'd0,
    FLAG_CALC = 2'd1,
    FLAG_ZERO = 2'd2,
    FLAG_KEEP = 2'd3
  } flag_sel_e;

  // Interrupt enable selects; the spare code keeps the flag.
  typedef enum logic [1:0] {
    INT_ONE  = 2'd0,
    INT_ZERO = 2'd1,
    INT_KEEP = 2'd2
  } int_sel_e;

  // Flag word, carry in the top bit down to interrupt enable in bit 0.
  typedef struct packed {
    logic carry;
    logic zero;
    logic overflow;
    logic negative;
    logic interrupt;
  } flags_t;

  // One operation as held in the input register.
  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    shift_sel_e shift_sel;
    logic_sel_e logic_sel;
    cin_sel_e   cin_sel;
    carry_sel_e carry_sel;
    flag_sel_e  zero_sel;
    flag_sel_e  overflow_sel;
    flag_sel_e  negative_sel;
    int_sel_e   interrupt_sel;
    flags_t     flags;
  } item_t;

  // Result byte and new flags from the datapath.
  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
  } alu_out_t;

endpackage

@@ sv/byte_alu_with_flag_selects.sv @@
// Byte ALU with flag selects: input register, datapath, result register.
// Flow: an accepted transaction is held in the input register, passes the datapath and
// is captured in the result register, which drives the result ports.
// Throughput: one transaction per cycle; busy_o stays low, so start_i may be high every cycle.
// done_o marks each result for exactly one cycle; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) clears the valid bits of both registers.
// Depends on bafs_pkg, bafs_datapath and byte_alu_with_flag_selects_assert.svh.
`include "byte_alu_with_flag_selects_assert.svh"

module byte_alu_with_flag_selects (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] left_operand_i,
  input  logic [7:0] right_operand_i,
  input  logic [1:0] shift_sel_i,
  input  logic [3:0] logic_sel_i,
  input  logic [1:0] carry_in_sel_i,
  input  logic [2:0] carry_sel_i,
  input  logic [1:0] zero_sel_i,
  input  logic [1:0] overflow_sel_i,
  input  logic [1:0] negative_sel_i,
  input  logic [1:0] interrupt_sel_i,
  input  logic [4:0] flags_now_i,
  output logic       done_o,
  output logic [7:0] result_byte_o,
  output logic       carry_out_o,
  output logic       zero_out_o,
  output logic       overflow_out_o,
  output logic       negative_out_o,
  output logic       interrupt_out_o
);

  bafs_pkg::item_t    item_d;
  bafs_pkg::item_t    item_q;
  logic               in_valid_q;
  bafs_pkg::alu_out_t alu_d;
  bafs_pkg::alu_out_t alu_q;
  logic               done_q;
  logic               accept;

  // The block never holds a transaction off.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Gather the input ports into one operation.
  always_comb begin
    item_d.left          = left_operand_i;
    item_d.right         = right_operand_i;
    item_d.shift_sel     = bafs_pkg::shift_sel_e'(shift_sel_i);
    item_d.logic_sel     = bafs_pkg::logic_sel_e'(logic_sel_i);
    item_d.cin_sel       = bafs_pkg::cin_sel_e'(carry_in_sel_i);
    item_d.carry_sel     = bafs_pkg::carry_sel_e'(carry_sel_i);
    item_d.zero_sel      = bafs_pkg::flag_sel_e'(zero_sel_i);
    item_d.overflow_sel  = bafs_pkg::flag_sel_e'(overflow_sel_i);
    item_d.negative_sel  = bafs_pkg::flag_sel_e'(negative_sel_i);
    item_d.interrupt_sel = bafs_pkg::int_sel_e'(interrupt_sel_i);
    item_d.flags         = bafs_pkg::flags_t'(flags_now_i);
  end

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  bafs_datapath u_datapath (
    .item_i (item_q),
    .alu_o  (alu_d)
  );

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      alu_q <= alu_d;
    end
  end

  assign done_o          = done_q;
  assign result_byte_o   = alu_q.result;
  assign carry_out_o     = alu_q.flags.carry;
  assign zero_out_o      = alu_q.flags.zero;
  assign overflow_out_o  = alu_q.flags.overflow;
  assign negative_out_o  = alu_q.flags.negative;
  assign interrupt_out_o = alu_q.flags.interrupt;

  // An accepted transaction is staged, then moves to the result register at the next edge.
  `BAFS_ASSERT_NEXT(a_accept_to_stage, clk_i, rst_ni, accept, in_valid_q,
                    "accepted transaction lost")
  `BAFS_ASSERT_NEXT(a_stage_to_done, clk_i, rst_ni, in_valid_q, done_o,
                    "staged transaction lost")
  // A computed zero flag matches the registered result byte.
  `BAFS_ASSERT_NEXT(a_zero_calc, clk_i, rst_ni,
                    in_valid_q && item_q.zero_sel == bafs_pkg::FLAG_CALC,
                    zero_out_o == (result_byte_o == 8'h00), "computed zero flag wrong")
  // A computed negative flag matches the sign of the result byte.
  `BAFS_ASSERT_NEXT(a_neg_calc, clk_i, rst_ni,
                    in_valid_q && item_q.negative_sel == bafs_pkg::FLAG_CALC,
                    negative_out_o == result_byte_o[7], "computed negative flag wrong")

endmodule

@@ sv/bafs_datapath.sv @@
// Combinational datapath of the byte ALU: shift and logic stages, adder, flag selection.
// Depends on bafs_pkg.
module bafs_datapath (
  input  bafs_pkg::item_t    item_i,
  output bafs_pkg::alu_out_t alu_o
);

  logic [7:0] sh;
  logic [7:0] lg;
  logic       cin;
  logic [8:0] sum;
  logic [7:0] res;
  logic       z_calc;
  logic       v_calc;
  logic       n_calc;

  // Picks one of forced one, computed, forced zero or kept.
  function automatic logic pick_flag(bafs_pkg::flag_sel_e sel, logic calc, logic kept);
    logic val;
    unique case (sel)
      bafs_pkg::FLAG_ONE:  val = 1'b1;
      bafs_pkg::FLAG_CALC: val = calc;
      bafs_pkg::FLAG_ZERO: val = 1'b0;
      default:             val = kept;
    endcase
    return val;
  endfunction

  // Shift stage on the left operand.
  always_comb begin
    unique case (item_i.shift_sel)
      bafs_pkg::SHIFT_PASS: sh = item_i.left;
      bafs_pkg::SHIFT_ROR:  sh = {item_i.flags.carry, item_i.left[7:1]};
      bafs_pkg::SHIFT_ASR:  sh = {item_i.left[7], item_i.left[7:1]};
      default:              sh = 8'h00;
    endcase
  end

  // Logic stage on both operands.
  always_comb begin
    unique case (item_i.logic_sel)
      bafs_pkg::LOGIC_ONES:      lg = 8'hff;
      bafs_pkg::LOGIC_LEFT:      lg = item_i.left;
      bafs_pkg::LOGIC_RIGHT:     lg = item_i.right;
      bafs_pkg::LOGIC_NOT_LEFT:  lg = ~item_i.left;
      bafs_pkg::LOGIC_NOT_RIGHT: lg = ~item_i.right;
      bafs_pkg::LOGIC_OR:        lg = item_i.left | item_i.right;
      bafs_pkg::LOGIC_AND:       lg = item_i.left & item_i.right;
      bafs_pkg::LOGIC_XOR:       lg = item_i.left ^ item_i.right;
      default:                   lg = 8'h00;
    endcase
  end

  // Adder carry-in.
  always_comb begin
    unique case (item_i.cin_sel)
      bafs_pkg::CIN_CARRY: cin = item_i.flags.carry;
      bafs_pkg::CIN_ONE:   cin = 1'b1;
      default:             cin = 1'b0;
    endcase
  end

  // Adder and computed flags.
  assign sum    = {1'b0, sh} + {1'b0, lg} + {8'h00, cin};
  assign res    = sum[7:0];
  assign z_calc = (res == 8'h00);
  assign v_calc = (sh[7] == lg[7]) && (res[7] != sh[7]);
  assign n_calc = res[7];

  // New flags as their selects say.
  always_comb begin
    alu_o.result = res;
    unique case (item_i.carry_sel)
      bafs_pkg::CARRY_ONE:   alu_o.flags.carry = 1'b1;
      bafs_pkg::CARRY_SHIFT: alu_o.flags.carry = item_i.left[0];
      bafs_pkg::CARRY_SUM:   alu_o.flags.carry = sum[8];
      bafs_pkg::CARRY_ZERO:  alu_o.flags.carry = 1'b0;
      default:               alu_o.flags.carry = item_i.flags.carry;
    endcase
    alu_o.flags.zero     = pick_flag(item_i.zero_sel, z_calc, item_i.flags.zero);
    alu_o.flags.overflow = pick_flag(item_i.overflow_sel, v_calc, item_i.flags.overflow);
    alu_o.flags.negative = pick_flag(item_i.negative_sel, n_calc, item_i.flags.negative);
    unique case (item_i.interrupt_sel)
      bafs_pkg::INT_ONE:  alu_o.flags.interrupt = 1'b1;
      bafs_pkg::INT_ZERO: alu_o.flags.interrupt = 1'b0;
      default:            alu_o.flags.interrupt = item_i.flags.interrupt;
    endcase
  end

endmodule

@@ tb/byte_alu_flag_checker.sv @@
`timescale 1ns / 100ps
// Checker for the byte ALU with flag selects: predicts each transaction and compares results.
// Depends on bafs_pkg; instantiated beside the block by tb_byte_alu_with_flag_selects.
module byte_alu_flag_checker
  import bafs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [7:0] left_operand_i,
  input  logic [7:0] right_operand_i,
  input  logic [1:0] shift_sel_i,
  input  logic [3:0] logic_sel_i,
  input  logic [1:0] carry_in_sel_i,
  input  logic [2:0] carry_sel_i,
  input  logic [1:0] zero_sel_i,
  input  logic [1:0] overflow_sel_i,
  input  logic [1:0] negative_sel_i,
  input  logic [1:0] interrupt_sel_i,
  input  logic [4:0] flags_now_i,
  input  logic       done_i,
  input  logic [7:0] result_byte_i,
  input  logic       carry_out_i,
  input  logic       zero_out_i,
  input  logic       overflow_out_i,
  input  logic       negative_out_i,
  input  logic       interrupt_out_i,
  output int         mismatch_count_o,
  output int         awaited_count_o
);

  alu_out_t awaited_results[$];
  int       mismatches;

  // Chooses one of the zero, overflow and negative flags from its select.
  function automatic logic choose_flag(logic [1:0] sel, logic computed, logic kept);
    case (sel)
      FLAG_ONE:  return 1'b1;
      FLAG_CALC: return computed;
      FLAG_ZERO: return 1'b0;
      default:   return kept;
    endcase
  endfunction

  // Works out the result byte and new flags of one operation.
  function automatic alu_out_t alu_outcome(
    logic [7:0] lhs, logic [7:0] rhs, logic [1:0] shift_sel, logic [3:0] logic_sel,
    logic [1:0] cin_sel, logic [2:0] carry_sel, logic [1:0] zero_sel,
    logic [1:0] ovf_sel, logic [1:0] neg_sel, logic [1:0] int_sel, flags_t now);
    logic [7:0] shifted;
    logic [7:0] combined;
    logic       cin;
    logic [8:0] sum;
    alu_out_t   outcome;

    case (shift_sel)
      SHIFT_PASS: shifted = lhs;
      SHIFT_ROR:  shifted = {now.carry, lhs[7:1]};
      SHIFT_ASR:  shifted = {lhs[7], lhs[7:1]};
      default:    shifted = 8'h00;
    endcase

    // Codes past XOR give zero, as does LOGIC_ZERO itself.
    case (logic_sel)
      LOGIC_ONES:      combined = 8'hff;
      LOGIC_LEFT:      combined = lhs;
      LOGIC_RIGHT:     combined = rhs;
      LOGIC_NOT_LEFT:  combined = ~lhs;
      LOGIC_NOT_RIGHT: combined = ~rhs;
      LOGIC_OR:        combined = lhs | rhs;
      LOGIC_AND:       combined = lhs & rhs;
      LOGIC_XOR:       combined = lhs ^ rhs;
      default:         combined = 8'h00;
    endcase

    case (cin_sel)
      CIN_CARRY: cin = now.carry;
      CIN_ONE:   cin = 1'b1;
      default:   cin = 1'b0;
    endcase

    sum = {1'b0, shifted} + {1'b0, combined} + {8'h00, cin};
    outcome.result = sum[7:0];

    // The spare carry codes keep the current carry.
    case (carry_sel)
      CARRY_ONE:   outcome.flags.carry = 1'b1;
      CARRY_SHIFT: outcome.flags.carry = lhs[0];
      CARRY_SUM:   outcome.flags.carry = sum[8];
      CARRY_ZERO:  outcome.flags.carry = 1'b0;
      default:     outcome.flags.carry = now.carry;
    endcase

    outcome.flags.zero = choose_flag(zero_sel, sum[7:0] == 8'h00, now.zero);
    outcome.flags.overflow = choose_flag(ovf_sel,
        (shifted[7] == combined[7]) && (sum[7] != shifted[7]), now.overflow);
    outcome.flags.negative = choose_flag(neg_sel, sum[7], now.negative);

    case (int_sel)
      INT_ONE:  outcome.flags.interrupt = 1'b1;
      INT_ZERO: outcome.flags.interrupt = 1'b0;
      default:  outcome.flags.interrupt = now.interrupt;
    endcase
    return outcome;
  endfunction

  // Counts a failure and reports the first ten in full.
  task automatic note_failure(string what, alu_out_t want, alu_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ERROR %s: expected %02h c%0b z%0b v%0b n%0b i%0b, got %02h c%0b z%0b v%0b n%0b i%0b",
               $realtime, what, want.result, want.flags.carry, want.flags.zero,
               want.flags.overflow, want.flags.negative, want.flags.interrupt,
               got.result, got.flags.carry, got.flags.zero, got.flags.overflow,
               got.flags.negative, got.flags.interrupt);
    end
  endtask

  // Retire results against the oldest expectation, then record newly accepted transactions.
  always @(posedge clk_i) begin
    alu_out_t got;
    alu_out_t want;
    if (rst_ni) begin
      if (done_i) begin
        got.result = result_byte_i;
        got.flags = '{carry_out_i, zero_out_i, overflow_out_i, negative_out_i,
                      interrupt_out_i};
        if (awaited_results.size() == 0) begin
          note_failure("result with no transaction awaiting", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.result !== want.result || got.flags.carry !== want.flags.carry ||
              got.flags.zero !== want.flags.zero ||
              got.flags.overflow !== want.flags.overflow ||
              got.flags.negative !== want.flags.negative ||
              got.flags.interrupt !== want.flags.interrupt) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_results.push_back(alu_outcome(left_operand_i, right_operand_i, shift_sel_i,
            logic_sel_i, carry_in_sel_i, carry_sel_i, zero_sel_i, overflow_sel_i,
            negative_sel_i, interrupt_sel_i, flags_t'(flags_now_i)));
      end
    end
    mismatch_count_o <= mismatches;
    awaited_count_o <= awaited_results.size();
  end

endmodule

@@ tb/tb_byte_alu_with_flag_selects.sv @@
`timescale 1ns / 100ps
// Testbench top for the byte ALU with flag selects: directed and random transactions with gaps.
// Depends on bafs_pkg, byte_alu_with_flag_selects and byte_alu_flag_checker.
module tb_byte_alu_with_flag_selects;
  import bafs_pkg::*;

  localparam int RandomOps = 1550;
  localparam int IdleLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [7:0] left_operand_i;
  logic [7:0] right_operand_i;
  logic [1:0] shift_sel_i;
  logic [3:0] logic_sel_i;
  logic [1:0] carry_in_sel_i;
  logic [2:0] carry_sel_i;
  logic [1:0] zero_sel_i;
  logic [1:0] overflow_sel_i;
  logic [1:0] negative_sel_i;
  logic [1:0] interrupt_sel_i;
  logic [4:0] flags_now_i;
  logic       done_o;
  logic [7:0] result_byte_o;
  logic       carry_out_o;
  logic       zero_out_o;
  logic       overflow_out_o;
  logic       negative_out_o;
  logic       interrupt_out_o;
  int         mismatch_count;
  int         awaited_count;
  int         idle_cycles;
  bit         steady_burst;

  byte_alu_with_flag_selects u_dut (.*);

  byte_alu_flag_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .left_operand_i, .right_operand_i,
    .shift_sel_i, .logic_sel_i, .carry_in_sel_i, .carry_sel_i, .zero_sel_i,
    .overflow_sel_i, .negative_sel_i, .interrupt_sel_i, .flags_now_i,
    .done_i(done_o), .result_byte_i(result_byte_o), .carry_out_i(carry_out_o),
    .zero_out_i(zero_out_o), .overflow_out_i(overflow_out_o),
    .negative_out_i(negative_out_o), .interrupt_out_i(interrupt_out_o),
    .mismatch_count_o(mismatch_count), .awaited_count_o(awaited_count)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap before the next transaction: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (steady_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one transaction at a falling edge and holds it until it is accepted.
  task automatic issue_op(logic [7:0] lhs, logic [7:0] rhs, logic [1:0] shift_sel,
                          logic [3:0] logic_sel, logic [1:0] cin_sel, logic [2:0] carry_sel,
                          logic [1:0] zero_sel, logic [1:0] ovf_sel, logic [1:0] neg_sel,
                          logic [1:0] int_sel, logic [4:0] flags);
    int gap;
    start_i <= 1'b1;
    left_operand_i <= lhs;
    right_operand_i <= rhs;
    shift_sel_i <= shift_sel;
    logic_sel_i <= logic_sel;
    carry_in_sel_i <= cin_sel;
    carry_sel_i <= carry_sel;
    zero_sel_i <= zero_sel;
    overflow_sel_i <= ovf_sel;
    negative_sel_i <= neg_sel;
    interrupt_sel_i <= int_sel;
    flags_now_i <= flags;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Operand bytes leaning on the edges of the range now and then.
  function automatic logic [7:0] pick_operand();
    logic [7:0] edges [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Ends the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("byte_alu_with_flag_selects test failed");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    static logic [7:0] edge_bytes [8] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55,
                                          8'haa};
    logic [3:0] code;
    rst_ni = 1'b0;
    start_i = 1'b0;
    left_operand_i = '0;
    right_operand_i = '0;
    shift_sel_i = '0;
    logic_sel_i = '0;
    carry_in_sel_i = '0;
    carry_sel_i = '0;
    zero_sel_i = '0;
    overflow_sel_i = '0;
    negative_sel_i = '0;
    interrupt_sel_i = '0;
    flags_now_i = '0;
    steady_burst = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every code of every select, the spare ones included, with edge operands.
    for (int i = 0; i < 16; i++) begin
      code = 4'(i);
      issue_op(edge_bytes[i % 8], edge_bytes[(i + 3) % 8], code[1:0], code, code[1:0],
               code[2:0], code[1:0], 2'(code + 1), 2'(code + 2), 2'(code + 3),
               code[0] ? 5'h1f : 5'h00);
    end

    // Rotate through a set carry, with the carry also fed into the adder.
    issue_op(8'h01, 8'h00, SHIFT_ROR, LOGIC_ZERO, CIN_CARRY, CARRY_SHIFT, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_KEEP, 5'h10);
    // Arithmetic shift keeps the sign bit.
    issue_op(8'h81, 8'h00, SHIFT_ASR, LOGIC_ZERO, CIN_ZERO, CARRY_SHIFT, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_ONE, 5'h00);
    // Positive overflow into the sign bit.
    issue_op(8'h7f, 8'h01, SHIFT_PASS, LOGIC_RIGHT, CIN_ZERO, CARRY_SUM, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_ZERO, 5'h1f);
    // Negative overflow with a carry out of the top bit.
    issue_op(8'h80, 8'h80, SHIFT_PASS, LOGIC_RIGHT, CIN_ZERO, CARRY_SUM, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_KEEP, 5'h00);
    // All ones plus all ones plus one wraps with carry.
    issue_op(8'hff, 8'h00, SHIFT_PASS, LOGIC_ONES, CIN_ONE, CARRY_SUM, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_KEEP, 5'h0f);
    // Zero result, flags computed.
    issue_op(8'hff, 8'hff, SHIFT_ZERO, LOGIC_ZERO, CIN_ZERO, CARRY_SUM, FLAG_CALC,
             FLAG_CALC, FLAG_CALC, INT_KEEP, 5'h1f);
    // Wrap to zero through the carry-in with every flag kept.
    issue_op(8'h00, 8'hff, SHIFT_ZERO, LOGIC_RIGHT, CIN_CARRY, CARRY_KEEP, FLAG_KEEP,
             FLAG_KEEP, FLAG_KEEP, INT_KEEP, 5'h1a);

    // Random transactions over the full width of every field.
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 50 == 0) steady_burst = ($urandom_range(0, 3) == 0);
      issue_op(pick_operand(), pick_operand(), 2'($urandom_range(0, 3)),
               4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
    end
    start_i <= 1'b0;

    // Drain the pipeline, then keep watching for stray results.
    while (awaited_count != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("byte_alu_with_flag_selects test passed");
    end else begin
      $display("byte_alu_with_flag_selects test failed");
    end
    $finish;
  end

endmodule
